>>> src/touch_swipe_key_classifier_macros.svh
// Assertion macros for the checker file of the touch swipe key classifier.
// Depends on nothing; take it in by `include.
`ifndef TOUCH_SWIPE_KEY_CLASSIFIER_MACROS_SVH
`define TOUCH_SWIPE_KEY_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSKC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TSKC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/tskc_pkg.sv
// Types and constants of the touch swipe key classifier.
// No dependencies; the design, checker and bench files refer to it by scoped names.
package tskc_pkg;

    localparam int unsigned COORD_W    = 12;
    localparam int unsigned KSIZE_W    = 10;
    localparam int unsigned COLS_W     = 4;
    localparam int unsigned KEY_W      = 8;
    localparam int unsigned DIR_W      = 3;
    localparam int unsigned FK_W       = 3;
    localparam int unsigned KANA_W     = 6;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 24;
    localparam int unsigned M_TUSER_W  = 2;
    localparam int unsigned DIV_CNT_W  = 4;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WIDTH   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_HEIGHT  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLUMNS     = 3'd6;

    localparam logic [COLS_W-1:0] COLUMNS_RESET = 4'd4;

    // Divider operand select
    localparam logic [1:0] DIV_SEL_X   = 2'd0;
    localparam logic [1:0] DIV_SEL_Y   = 2'd1;
    localparam logic [1:0] DIV_SEL_KEY = 2'd2;

    localparam logic [DIR_W-1:0] DIR_CENTER = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd1;
    localparam logic [DIR_W-1:0] DIR_UP     = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN   = 3'd4;

    localparam logic [FK_W-1:0] FK_NONE      = 3'd0;
    localparam logic [FK_W-1:0] FK_BACKSPACE = 3'd1;
    localparam logic [FK_W-1:0] FK_CONVERT   = 3'd2;
    localparam logic [FK_W-1:0] FK_COMMIT    = 3'd3;
    localparam logic [FK_W-1:0] FK_MODE      = 3'd4;

    localparam int unsigned THRESH_MIN      = 12;
    localparam int unsigned THRESH_DIV      = 3;
    localparam int unsigned KANA_ROW_STRIDE = 15;
    localparam int unsigned KANA_COL_STRIDE = 5;
    localparam int unsigned FK_COLUMN       = 3;
    localparam int unsigned KANA_ROWS       = 4;
    localparam int unsigned KANA_COLS       = 3;
    localparam int unsigned EMPTY_ROW       = 3;

    // Result payload, key_number in the lowest bits
    typedef struct packed {
        logic              kana_present;
        logic [KANA_W-1:0] kana_code;
        logic [FK_W-1:0]   function_key;
        logic [DIR_W-1:0]  direction;
        logic [KEY_W-1:0]  key_number;
    } tskc_result_t;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic [1:0] div_sel;
        logic       store_col;
        logic       res_zero;
        logic       res_press;
        logic       res_release;
        logic       out_load;
    } tskc_cmd_t;

    typedef struct packed {
        logic is_release;
        logic pending;
        logic hit_ok;
        logic div_done;
        logic out_free;
    } tskc_status_t;

endpackage

>>> src/tskc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tskc_pkg.
module tskc_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [tskc_pkg::COORD_W-1:0]   dividend,
    input  logic [tskc_pkg::KSIZE_W-1:0]   divisor,
    output logic [tskc_pkg::COORD_W-1:0]   quotient,
    output logic [tskc_pkg::KSIZE_W-1:0]   remainder,
    output logic                           done
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [tskc_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tskc_pkg::COORD_W-1:0]      quo_reg, quo_next;
    logic [tskc_pkg::KSIZE_W-1:0]      rem_reg, rem_next;
    logic [tskc_pkg::KSIZE_W-1:0]      dsr_reg, dsr_next;
    logic [tskc_pkg::KSIZE_W:0]        trial;
    logic                              ge;

    assign trial = {rem_reg, quo_reg[tskc_pkg::COORD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? tskc_pkg::KSIZE_W'(trial - {1'b0, dsr_reg})
                          : trial[tskc_pkg::KSIZE_W-1:0];
            quo_next = {quo_reg[tskc_pkg::COORD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tskc_pkg::DIV_CNT_W'(tskc_pkg::COORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> src/tskc_dp.sv
// Datapath: configuration registers, input capture, hit test, press state,
// swipe classification and output register. Depends on tskc_pkg, tskc_div.
module tskc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tskc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tskc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [tskc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tskc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [tskc_pkg::M_TUSER_W-1:0]    m_tuser,
    input  tskc_pkg::tskc_cmd_t               cmd,
    output tskc_pkg::tskc_status_t            status
);

    localparam int unsigned CW = tskc_pkg::COORD_W;
    localparam int unsigned KW = tskc_pkg::KSIZE_W;
    localparam int unsigned TW = CW + 2;

    // Configuration
    logic [CW-1:0]                 origin_x_reg, origin_y_reg;
    logic [CW-1:0]                 area_width_reg, area_height_reg;
    logic [KW-1:0]                 key_width_reg, key_height_reg;
    logic [tskc_pkg::COLS_W-1:0]   columns_reg;
    logic [tskc_pkg::COLS_W-1:0]   cols_eff;

    // Captured item and press state
    logic                          func_reg;
    logic [CW-1:0]                 tx_reg, ty_reg;
    logic                          pending_reg, pending_next;
    logic [tskc_pkg::KEY_W-1:0]    pkey_reg;
    logic [CW-1:0]                 ppx_reg, ppy_reg;
    logic [tskc_pkg::KEY_W-1:0]    col_reg;

    // Result staging and output register
    tskc_pkg::tskc_result_t        res_reg, res_next;
    logic                          res_press_reg, res_rel_reg;
    tskc_pkg::tskc_result_t        out_reg;
    logic [tskc_pkg::M_TUSER_W-1:0] out_user_reg;
    logic                          out_valid_reg, out_valid_next;

    // Divider
    logic [CW-1:0]                 div_dividend;
    logic [KW-1:0]                 div_divisor;
    logic [CW-1:0]                 div_quo;
    logic [KW-1:0]                 div_rem;
    logic                          div_done;

    logic                          hit;
    logic [tskc_pkg::KEY_W-1:0]    new_key;
    logic [CW-1:0]                 adx, ady;
    logic                          x_small, y_small;
    logic [tskc_pkg::DIR_W-1:0]    dir;
    logic [tskc_pkg::KEY_W-1:0]    rel_row;
    logic [tskc_pkg::COLS_W-1:0]   rel_col;
    logic [tskc_pkg::FK_W-1:0]     fk;
    logic [tskc_pkg::KANA_W-1:0]   kana;
    logic                          kana_ok;

    // Offset below max(12, key_width/3): v < floor(kw/3) iff 3*(v+1) <= kw.
    function automatic logic below_thr(input logic [CW-1:0] v, input logic [KW-1:0] kw);
        logic [TW-1:0] v3;
        v3 = TW'(v) * TW'(tskc_pkg::THRESH_DIV) + TW'(tskc_pkg::THRESH_DIV);
        return (v < CW'(tskc_pkg::THRESH_MIN)) || (v3 <= TW'(kw));
    endfunction

    assign cols_eff = (columns_reg == '0) ? tskc_pkg::COLS_W'(1) : columns_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            area_width_reg  <= '0;
            area_height_reg <= '0;
            key_width_reg   <= '0;
            key_height_reg  <= '0;
            columns_reg     <= tskc_pkg::COLUMNS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tskc_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                tskc_pkg::CFG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                tskc_pkg::CFG_AREA_WIDTH:  area_width_reg  <= cfg_wdata;
                tskc_pkg::CFG_AREA_HEIGHT: area_height_reg <= cfg_wdata;
                tskc_pkg::CFG_KEY_WIDTH:   key_width_reg   <= cfg_wdata[KW-1:0];
                tskc_pkg::CFG_KEY_HEIGHT:  key_height_reg  <= cfg_wdata[KW-1:0];
                tskc_pkg::CFG_COLUMNS:     columns_reg     <= cfg_wdata[tskc_pkg::COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Half-open hit test on both axes, plus nonzero key size
    assign hit = (tx_reg >= origin_x_reg)
              && ({1'b0, tx_reg} < ({1'b0, origin_x_reg} + {1'b0, area_width_reg}))
              && (ty_reg >= origin_y_reg)
              && ({1'b0, ty_reg} < ({1'b0, origin_y_reg} + {1'b0, area_height_reg}))
              && (key_width_reg != '0) && (key_height_reg != '0);

    always_comb begin
        case (cmd.div_sel)
            tskc_pkg::DIV_SEL_X: begin
                div_dividend = tx_reg - origin_x_reg;
                div_divisor  = key_width_reg;
            end
            tskc_pkg::DIV_SEL_Y: begin
                div_dividend = ty_reg - origin_y_reg;
                div_divisor  = key_height_reg;
            end
            default: begin
                div_dividend = CW'(pkey_reg);
                div_divisor  = KW'(cols_eff);
            end
        endcase
    end

    tskc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Key number wraps to 8 bits, so only the low bits of row and column count
    assign new_key = tskc_pkg::KEY_W'(div_quo[tskc_pkg::KEY_W-1:0] * cols_eff) + col_reg;

    // Swipe direction
    assign adx     = (tx_reg >= ppx_reg) ? tx_reg - ppx_reg : ppx_reg - tx_reg;
    assign ady     = (ty_reg >= ppy_reg) ? ty_reg - ppy_reg : ppy_reg - ty_reg;
    assign x_small = below_thr(adx, key_width_reg);
    assign y_small = below_thr(ady, key_width_reg);

    always_comb begin
        if (x_small && y_small) begin
            dir = tskc_pkg::DIR_CENTER;
        end else if (adx > ady) begin
            dir = (tx_reg < ppx_reg) ? tskc_pkg::DIR_LEFT : tskc_pkg::DIR_RIGHT;
        end else begin
            dir = (ty_reg < ppy_reg) ? tskc_pkg::DIR_UP : tskc_pkg::DIR_DOWN;
        end
    end

    assign rel_row = div_quo[tskc_pkg::KEY_W-1:0];
    assign rel_col = div_rem[tskc_pkg::COLS_W-1:0];

    always_comb begin
        fk      = tskc_pkg::FK_NONE;
        kana    = '0;
        kana_ok = 1'b0;
        if (rel_col == tskc_pkg::COLS_W'(tskc_pkg::FK_COLUMN)) begin
            fk = (rel_row < tskc_pkg::KEY_W'(tskc_pkg::FK_COLUMN))
               ? tskc_pkg::FK_W'(rel_row[1:0]) + tskc_pkg::FK_BACKSPACE
               : tskc_pkg::FK_MODE;
        end else if ((rel_row < tskc_pkg::KEY_W'(tskc_pkg::KANA_ROWS))
                  && (rel_col < tskc_pkg::COLS_W'(tskc_pkg::KANA_COLS))) begin
            kana = tskc_pkg::KANA_W'(rel_row[1:0]) * tskc_pkg::KANA_W'(tskc_pkg::KANA_ROW_STRIDE)
                 + tskc_pkg::KANA_W'(rel_col[1:0]) * tskc_pkg::KANA_W'(tskc_pkg::KANA_COL_STRIDE)
                 + tskc_pkg::KANA_W'(dir);
            // Row 3, column 0 has no entries for right and down
            kana_ok = !((rel_row == tskc_pkg::KEY_W'(tskc_pkg::EMPTY_ROW)) && (rel_col == '0)
                        && (dir >= tskc_pkg::DIR_RIGHT));
        end
    end

    always_comb begin
        pending_next = pending_reg;
        res_next     = res_reg;
        if (cmd.res_zero) begin
            pending_next = 1'b0;
            res_next     = '0;
        end else if (cmd.res_press) begin
            pending_next          = 1'b1;
            res_next              = '0;
            res_next.key_number   = new_key;
        end else if (cmd.res_release) begin
            pending_next          = 1'b0;
            res_next.key_number   = pkey_reg;
            res_next.direction    = dir;
            res_next.function_key = fk;
            res_next.kana_code    = kana;
            res_next.kana_present = kana_ok;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
        if (cmd.load_in) begin
            func_reg <= s_tuser;
            tx_reg   <= s_tdata[CW-1:0];
            ty_reg   <= s_tdata[2*CW-1:CW];
        end
        if (cmd.store_col) begin
            col_reg <= div_quo[tskc_pkg::KEY_W-1:0];
        end
        if (cmd.res_press) begin
            pkey_reg <= new_key;
            ppx_reg  <= tx_reg;
            ppy_reg  <= ty_reg;
        end
        if (cmd.res_zero || cmd.res_press || cmd.res_release) begin
            res_press_reg <= cmd.res_press;
            res_rel_reg   <= cmd.res_release;
        end
        res_reg <= res_next;
        if (cmd.out_load) begin
            out_reg      <= res_reg;
            out_user_reg <= {res_rel_reg, res_press_reg};
        end
    end

    assign status.is_release = func_reg;
    assign status.pending    = pending_reg;
    assign status.hit_ok     = hit;
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tskc_pkg::M_TDATA_W'(out_reg);
    assign m_tuser  = out_user_reg;

endmodule

>>> src/tskc_ctrl.sv
// Controller state machine: sequences capture, divisions and result hand-off.
// Depends on tskc_pkg.
module tskc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  tskc_pkg::tskc_status_t  status,
    output tskc_pkg::tskc_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV_X = 3'd2;
    localparam logic [2:0] ST_DIV_Y = 3'd3;
    localparam logic [2:0] ST_DIV_K = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = tskc_pkg::DIV_SEL_KEY;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.is_release) begin
                    if (status.pending) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = tskc_pkg::DIV_SEL_KEY;
                        state_next    = ST_DIV_K;
                    end else begin
                        cmd.res_zero = 1'b1;
                        state_next   = ST_OUT;
                    end
                end else if (status.hit_ok) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = tskc_pkg::DIV_SEL_X;
                    state_next    = ST_DIV_X;
                end else begin
                    // Miss: drop any pending press
                    cmd.res_zero = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_DIV_X: begin
                if (status.div_done) begin
                    cmd.store_col = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = tskc_pkg::DIV_SEL_Y;
                    state_next    = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                cmd.div_sel = tskc_pkg::DIV_SEL_Y;
                if (status.div_done) begin
                    cmd.res_press = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_DIV_K: begin
                if (status.div_done) begin
                    cmd.res_release = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the output register can take the result
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/touch_swipe_key_classifier.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: touch_x, touch_y; s_tuser: func
// m_        out  m_tvalid/m_tready  m_tdata: key, dir, fkey, kana; m_tuser: flags
// cfg_      in   cfg_wr_en          cfg_addr selects register, cfg_wdata value
//
// Items are taken one at a time: a press on the grid runs two 12-step passes
// of the serial divider (column, then row), a release with a press pending
// one divider pass for the row/column split, and any other event no divider
// pass. The next item is taken while a result waits in the output register.
// Reset is synchronous, active low; no clearing pass.
module touch_swipe_key_classifier (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tskc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tskc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tskc_pkg::S_TDATA_W-1:0]    s_tdata,  // touch_x[11:0], touch_y[23:12]
    input  logic                              s_tuser,  // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // key_number[7:0], direction[10:8], function_key[13:11], kana_code[19:14],
    // kana_present[20], zero[23:21]
    output logic [tskc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [tskc_pkg::M_TUSER_W-1:0]    m_tuser   // press_accepted[0], release_valid[1]
);

    tskc_pkg::tskc_cmd_t    cmd;
    tskc_pkg::tskc_status_t status;

    tskc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tskc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> src/tskc_checker.sv
// Port-level checks for touch_swipe_key_classifier, bound to the top level.
// Depends on tskc_pkg and touch_swipe_key_classifier_macros.svh.
`include "touch_swipe_key_classifier_macros.svh"

module tskc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tskc_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [tskc_pkg::M_TUSER_W-1:0]   m_tuser
);

    // A result is a press or a release, never both
    `TSKC_ASSERT_IMP(a_flags_excl, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))

    // Accepted press carries only the key number
    `TSKC_ASSERT_IMP(a_press_only_key, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[23:8] == '0)

    // Rejected or unmatched events give an all-zero result
    `TSKC_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_tvalid && (m_tuser == '0), m_tdata == '0)

    // Function keys carry no kana
    `TSKC_ASSERT_IMP(a_fk_no_kana, aclk, aresetn, m_tvalid && (m_tdata[13:11] != '0), m_tdata[20:14] == '0)

    // Stalled transfer holds
    `TSKC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind touch_swipe_key_classifier tskc_checker u_tskc_checker (.*);

>>> sim/touch_swipe_key_classifier_test.sv
// Self-checking bench for touch_swipe_key_classifier: press/release stimulus with random
// gaps and stalls, results predicted in a scoreboard class and checked in order.
// Depends on tskc_pkg and the RTL under src/.
module touch_swipe_key_classifier_test;

    typedef struct {
        bit                     pressed;
        bit                     released;
        tskc_pkg::tskc_result_t fields;
    } touch_outcome_t;

    class swipe_scoreboard_t;
        logic [tskc_pkg::COORD_W-1:0] org_x, org_y, span_x, span_y;
        logic [tskc_pkg::KSIZE_W-1:0] key_w, key_h;
        logic [tskc_pkg::COLS_W-1:0]  n_cols;
        bit                           holding;
        logic [tskc_pkg::KEY_W-1:0]   held_key;
        logic [tskc_pkg::COORD_W-1:0] hold_x, hold_y;
        touch_outcome_t               awaited[$];
        int unsigned                  errors;
        int unsigned                  checked;

        function new();
            org_x = '0;
            org_y = '0;
            span_x = '0;
            span_y = '0;
            key_w = '0;
            key_h = '0;
            n_cols = tskc_pkg::COLUMNS_RESET;
            holding = 1'b0;
            held_key = '0;
            hold_x = '0;
            hold_y = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [tskc_pkg::CFG_ADDR_W-1:0] idx,
                              logic [tskc_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                tskc_pkg::CFG_ORIGIN_X:    org_x = val;
                tskc_pkg::CFG_ORIGIN_Y:    org_y = val;
                tskc_pkg::CFG_AREA_WIDTH:  span_x = val;
                tskc_pkg::CFG_AREA_HEIGHT: span_y = val;
                tskc_pkg::CFG_KEY_WIDTH:   key_w = val[tskc_pkg::KSIZE_W-1:0];
                tskc_pkg::CFG_KEY_HEIGHT:  key_h = val[tskc_pkg::KSIZE_W-1:0];
                tskc_pkg::CFG_COLUMNS:     n_cols = val[tskc_pkg::COLS_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // Work out the outcome of one accepted touch event and queue it.
        function void note_event(bit lift, logic [tskc_pkg::COORD_W-1:0] x,
                                 logic [tskc_pkg::COORD_W-1:0] y);
            touch_outcome_t             o;
            int unsigned                cols, col, row, thr, adx, ady, ox, oy;
            logic [tskc_pkg::DIR_W-1:0] dir;
            o.pressed = 1'b0;
            o.released = 1'b0;
            o.fields = '0;
            cols = (n_cols == 0) ? 1 : n_cols;
            ox = org_x;
            oy = org_y;
            if (!lift) begin
                if (x >= ox && x < ox + span_x && y >= oy && y < oy + span_y &&
                    key_w != 0 && key_h != 0) begin
                    col = (x - ox) / key_w;
                    row = (y - oy) / key_h;
                    held_key = tskc_pkg::KEY_W'(row * cols + col);
                    holding = 1'b1;
                    hold_x = x;
                    hold_y = y;
                    o.pressed = 1'b1;
                    o.fields.key_number = held_key;
                end else begin
                    holding = 1'b0;
                end
            end else if (holding) begin
                thr = key_w / tskc_pkg::THRESH_DIV;
                if (thr < tskc_pkg::THRESH_MIN)
                    thr = tskc_pkg::THRESH_MIN;
                adx = (x >= hold_x) ? x - hold_x : hold_x - x;
                ady = (y >= hold_y) ? y - hold_y : hold_y - y;
                if (adx < thr && ady < thr)
                    dir = tskc_pkg::DIR_CENTER;
                else if (adx > ady)
                    dir = (x < hold_x) ? tskc_pkg::DIR_LEFT : tskc_pkg::DIR_RIGHT;
                else
                    dir = (y < hold_y) ? tskc_pkg::DIR_UP : tskc_pkg::DIR_DOWN;
                row = held_key / cols;
                col = held_key % cols;
                holding = 1'b0;
                o.released = 1'b1;
                o.fields.key_number = held_key;
                o.fields.direction = dir;
                if (col == tskc_pkg::FK_COLUMN) begin
                    case (row)
                        0: o.fields.function_key = tskc_pkg::FK_BACKSPACE;
                        1: o.fields.function_key = tskc_pkg::FK_CONVERT;
                        2: o.fields.function_key = tskc_pkg::FK_COMMIT;
                        default: o.fields.function_key = tskc_pkg::FK_MODE;
                    endcase
                end else if (row < tskc_pkg::KANA_ROWS && col < tskc_pkg::KANA_COLS) begin
                    o.fields.kana_code = tskc_pkg::KANA_W'(row * tskc_pkg::KANA_ROW_STRIDE +
                                                           col * tskc_pkg::KANA_COL_STRIDE +
                                                           dir);
                    // row 3, column 0 has no kana for right and down
                    o.fields.kana_present = !(row == tskc_pkg::EMPTY_ROW && col == 0 &&
                                              dir >= tskc_pkg::DIR_RIGHT);
                end
            end
            awaited.push_back(o);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch in result %0d, %s: got %0h, expected %0h",
                     checked, what, got, want);
        endtask

        task compare(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report(what, got, want);
        endtask

        task check_result(logic [tskc_pkg::M_TDATA_W-1:0] data,
                          logic [tskc_pkg::M_TUSER_W-1:0] flags);
            touch_outcome_t         want;
            tskc_pkg::tskc_result_t got;
            checked++;
            if (awaited.size() == 0) begin
                report("result with nothing expected", data, 0);
                return;
            end
            want = awaited.pop_front();
            got = data[$bits(tskc_pkg::tskc_result_t)-1:0];
            compare("press_accepted", flags[0], want.pressed);
            compare("release_valid", flags[1], want.released);
            compare("key_number", got.key_number, want.fields.key_number);
            compare("direction", got.direction, want.fields.direction);
            compare("function_key", got.function_key, want.fields.function_key);
            compare("kana_code", got.kana_code, want.fields.kana_code);
            compare("kana_present", got.kana_present, want.fields.kana_present);
            compare("tdata padding",
                    data[tskc_pkg::M_TDATA_W-1:$bits(tskc_pkg::tskc_result_t)], 0);
        endtask
    endclass

    localparam int unsigned LONG_HOLD = 400;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [tskc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [tskc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tskc_pkg::S_TDATA_W-1:0]  s_tdata = '0;   // touch_x[11:0], touch_y[23:12]
    logic                            s_tuser = 1'b0; // func
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tskc_pkg::M_TDATA_W-1:0]  m_tdata;        // key, direction, function_key, kana, present
    logic [tskc_pkg::M_TUSER_W-1:0]  m_tuser;        // press_accepted, release_valid

    bit          send_gaps = 1'b1;
    logic        ready_gaps = 1'b1;
    int unsigned holds_asked = 0;
    int unsigned holds_served = 0;
    int unsigned stall_left = 0;

    swipe_scoreboard_t sb = new();

    touch_swipe_key_classifier DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: random stalls, plus a long hold whenever the stimulus asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (holds_served != holds_asked) begin
            m_tready <= 1'b0;
            stall_left <= LONG_HOLD;
            holds_served <= holds_asked;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (ready_gaps && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!send_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Coordinate on the hit area, now and then on or just past its edges.
    function automatic int unsigned pick_inside(int unsigned org, int unsigned span);
        int unsigned r, v;
        if (span == 0)
            return $urandom_range(0, 4095);
        r = $urandom_range(0, 99);
        if (r < 6)
            v = org;
        else if (r < 12)
            v = org + span - 1;
        else if (r < 16)
            v = org + span;
        else
            v = org + $urandom_range(0, span - 1);
        return (v > 4095) ? $urandom_range(org, 4095) : v;
    endfunction

    function automatic int unsigned pick_reach();
        int unsigned thr, r;
        thr = sb.key_w / tskc_pkg::THRESH_DIV;
        if (thr < tskc_pkg::THRESH_MIN)
            thr = tskc_pkg::THRESH_MIN;
        r = $urandom_range(0, 99);
        if (r < 35)
            return thr - 1;
        if (r < 85)
            return 3 * thr;
        return 4095;
    endfunction

    function automatic int unsigned nudge(int unsigned p, int unsigned reach);
        int v;
        v = int'(p) + int'($urandom_range(0, 2 * reach)) - int'(reach);
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // Offer one event, hold it until the transfer, then maybe idle.
    task automatic send_touch(input bit lift, input int unsigned x, input int unsigned y);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser <= lift;
        s_tdata <= {tskc_pkg::COORD_W'(y), tskc_pkg::COORD_W'(x)};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_event(lift, tskc_pkg::COORD_W'(x), tskc_pkg::COORD_W'(y));
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tskc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [tskc_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_grid(input int unsigned ox, input int unsigned oy,
                            input int unsigned aw, input int unsigned ah,
                            input int unsigned kw, input int unsigned kh,
                            input int unsigned cols);
        write_reg(tskc_pkg::CFG_ORIGIN_X, tskc_pkg::CFG_DATA_W'(ox));
        write_reg(tskc_pkg::CFG_ORIGIN_Y, tskc_pkg::CFG_DATA_W'(oy));
        write_reg(tskc_pkg::CFG_AREA_WIDTH, tskc_pkg::CFG_DATA_W'(aw));
        write_reg(tskc_pkg::CFG_AREA_HEIGHT, tskc_pkg::CFG_DATA_W'(ah));
        write_reg(tskc_pkg::CFG_KEY_WIDTH, tskc_pkg::CFG_DATA_W'(kw));
        write_reg(tskc_pkg::CFG_KEY_HEIGHT, tskc_pkg::CFG_DATA_W'(kh));
        write_reg(tskc_pkg::CFG_COLUMNS, tskc_pkg::CFG_DATA_W'(cols));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_typical_grid();
        int unsigned cols, kw, kh, aw, ah;
        cols = $urandom_range(1, 5);
        kw = $urandom_range(12, 300);
        kh = $urandom_range(12, 300);
        aw = kw * cols + $urandom_range(0, kw - 1);
        ah = kh * $urandom_range(1, 5) + $urandom_range(0, kh - 1);
        if (aw > 4095)
            aw = 4095;
        if (ah > 4095)
            ah = 4095;
        set_grid($urandom_range(0, 4095 - aw), $urandom_range(0, 4095 - ah),
                 aw, ah, kw, kh, cols);
    endtask

    // Mostly press/release pairs on the grid; the rest double presses, stray presses
    // between press and release, and events with arbitrary fields.
    task automatic run_touch_phase(input int unsigned count, input bit hold_mid,
                                   input bit drain_mid);
        int unsigned sent, kind, px, py;
        sent = 0;
        while (sent < count) begin
            if (hold_mid && sent >= count / 2) begin
                holds_asked <= holds_asked + 1;
                hold_mid = 1'b0;
            end
            if (drain_mid && sent >= count / 2) begin
                wait_for_results();
                drain_mid = 1'b0;
            end
            kind = $urandom_range(0, 99);
            px = pick_inside(sb.org_x, sb.span_x);
            py = pick_inside(sb.org_y, sb.span_y);
            if (kind < 88) begin
                send_touch(1'b0, px, py);
                if (kind >= 70 && kind < 80) begin
                    px = pick_inside(sb.org_x, sb.span_x);
                    py = pick_inside(sb.org_y, sb.span_y);
                    send_touch(1'b0, px, py);
                    sent++;
                end else if (kind >= 80) begin
                    send_touch(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095));
                    sent++;
                end
                send_touch(1'b1, nudge(px, pick_reach()), nudge(py, pick_reach()));
                sent += 2;
            end else begin
                send_touch(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                           $urandom_range(0, 4095));
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: zero key size rejects every press
        run_touch_phase(20, 1'b0, 1'b0);
        wait_for_results();

        // 5x5 keys of 80x60 on a four-column grid, threshold 26
        set_grid(100, 50, 400, 300, 80, 60, 4);
        send_touch(1'b1, 0, 0);
        send_touch(1'b0, 0, 0);
        send_touch(1'b0, 4095, 4095);
        send_touch(1'b0, 100, 50);
        send_touch(1'b1, 110, 60);
        send_touch(1'b0, 350, 60);
        send_touch(1'b1, 310, 60);
        send_touch(1'b0, 350, 120);
        send_touch(1'b1, 350, 80);
        send_touch(1'b0, 350, 180);
        send_touch(1'b1, 390, 180);
        send_touch(1'b0, 350, 295);
        send_touch(1'b1, 350, 340);
        send_touch(1'b0, 110, 235);
        send_touch(1'b1, 150, 235);
        send_touch(1'b0, 110, 235);
        // equal offsets beyond the threshold count as vertical
        send_touch(1'b1, 140, 265);
        send_touch(1'b0, 499, 349);
        send_touch(1'b1, 0, 0);
        send_touch(1'b0, 425, 55);
        // press just past the right edge drops the pending one
        send_touch(1'b0, 500, 50);
        send_touch(1'b1, 425, 55);
        send_touch(1'b0, 180, 110);
        send_touch(1'b1, 205, 85);
        send_touch(1'b0, 180, 110);
        send_touch(1'b1, 206, 110);
        wait_for_results();

        set_grid(0, 0, 4095, 4095, 1023, 1023, 15);
        run_touch_phase(60, 1'b1, 1'b0);
        wait_for_results();
        set_grid(4095, 4095, 4095, 4095, 1, 1, 0);
        run_touch_phase(60, 1'b0, 1'b1);
        wait_for_results();
        set_grid(0, 0, 4095, 4095, 1, 1, 15);
        run_touch_phase(60, 1'b0, 1'b0);
        wait_for_results();
        set_grid(0, 0, 0, 0, 1023, 0, 1);
        run_touch_phase(30, 1'b0, 1'b0);
        wait_for_results();

        for (n = 0; n < 10; n++) begin
            send_gaps = (n % 4 != 1);
            ready_gaps <= (n % 4 != 1);
            if (n % 3 == 2)
                set_grid($urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095));
            else
                set_typical_grid();
            run_touch_phase(80, n == 4, n == 6);
            wait_for_results();
        end

        repeat (40) @(posedge aclk);
        if (sb.outstanding() != 0)
            sb.report("results never delivered", sb.outstanding(), 0);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
